>>> hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, codes and types of the polyline signed distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int unsigned MAX_VERTICES = 1024;
    localparam int unsigned VIDX_W       = 10;
    localparam int unsigned CNT_W        = 11;
    localparam int unsigned COORD_W      = 32;
    localparam int unsigned VERT_W       = 2 * COORD_W;

    localparam int unsigned DIFF_W       = COORD_W + 1;
    localparam int unsigned MAG_W        = COORD_W;
    localparam int unsigned PROD_W       = 2 * MAG_W;
    localparam int unsigned SUM_W        = PROD_W + 2;
    localparam int unsigned LEN_W        = PROD_W + 1;
    localparam int unsigned CMAG_W       = PROD_W + 1;
    localparam int unsigned C2_W         = 2 * CMAG_W;
    localparam int unsigned SQ_CNT_W     = $clog2(CMAG_W);
    localparam int unsigned MUL_STEPS    = 8;
    localparam int unsigned STEP_W       = $clog2(MUL_STEPS + 1);

    localparam int unsigned ROOT_BITS    = 31;
    localparam int unsigned LS_W         = LEN_W + 2 * (ROOT_BITS - 1);
    localparam int unsigned BS_W         = LEN_W + 2 * ROOT_BITS + 1;
    localparam int unsigned S_W          = BS_W + 1;
    localparam int unsigned T_W          = C2_W + 1;

    localparam int unsigned DIST_W       = 32;
    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;

    // fifo depth must be a power of two
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;
    localparam logic        REG_VERTEX_COUNT = 1'b0;

    localparam logic        OP_QUERY     = 1'b1;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [VIDX_W-1:0]          vidx;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_cmd;

    typedef struct packed {
        logic signed [DIST_W-1:0]   sdist;
        logic                       found;
        logic [VIDX_W-1:0]          seg;
        logic                       on_track;
    } t_result;

endpackage

>>> hdl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Input stage: takes one beat, decodes it into a write or query command.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_opcode,
    input  logic [psd_pkg::VIDX_W-1:0]          i_vertex_index,
    input  logic signed [psd_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                o_q_push,
    output psd_pkg::t_cmd                       o_q_data,
    input  logic                                i_q_full
);

    logic          r_valid;
    logic          n_valid;
    psd_pkg::t_cmd r_cmd;
    psd_pkg::t_cmd n_cmd;
    logic          w_accept;

    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign n_valid  = w_accept || (r_valid && i_q_full);

    always_comb begin
        n_cmd.kind = (i_opcode == psd_pkg::OP_QUERY) ? psd_pkg::KIND_QUERY
                                                      : psd_pkg::KIND_WRITE;
        n_cmd.vidx = i_vertex_index;
        n_cmd.x    = i_coord_x;
        n_cmd.y    = i_coord_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_cmd;

endmodule

>>> hdl/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Short command fifo between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module psd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output psd_pkg::t_cmd o_data
);

    psd_pkg::t_cmd                r_slot [psd_pkg::FIFO_DEPTH];
    logic [psd_pkg::FIFO_AW-1:0]  r_wp;
    logic [psd_pkg::FIFO_AW-1:0]  r_rp;
    logic [psd_pkg::FIFO_AW:0]    r_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_full  = (r_cnt == (psd_pkg::FIFO_AW+1)'(psd_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Execution engine: fence memory, segment walker, shared 32x32 multiplier,
// bit-serial squaring and square root, nearest segment tracking.
// ----------------------------------------------------------------------------
module psd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [psd_pkg::CNT_W-1:0]   i_vertex_count,
    input  logic                        i_cmd_empty,
    input  psd_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    input  logic                        i_res_pop,
    output logic                        o_res_empty,
    output psd_pkg::t_result            o_res
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_LDV0 = 12'b0000_0000_0010,
        ST_RDK  = 12'b0000_0000_0100,
        ST_LDV1 = 12'b0000_0000_1000,
        ST_DIFF = 12'b0000_0001_0000,
        ST_MUL  = 12'b0000_0010_0000,
        ST_CHK  = 12'b0000_0100_0000,
        ST_SQR  = 12'b0000_1000_0000,
        ST_ROOT = 12'b0001_0000_0000,
        ST_CMP  = 12'b0010_0000_0000,
        ST_NEXT = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        ACC_P1  = 2'd0,
        ACC_P2  = 2'd1,
        ACC_CR  = 2'd2,
        ACC_LEN = 2'd3
    } t_acc;

    function automatic logic [psd_pkg::MAG_W-1:0] f_mag(
        input logic [psd_pkg::DIFF_W-1:0] v
    );
        logic [psd_pkg::DIFF_W-1:0] t;
        t = v[psd_pkg::DIFF_W-1] ? (~v + 1'b1) : v;
        return t[psd_pkg::MAG_W-1:0];
    endfunction

    function automatic logic [psd_pkg::DIFF_W-1:0] f_sub(
        input logic [psd_pkg::COORD_W-1:0] a,
        input logic [psd_pkg::COORD_W-1:0] b
    );
        return {a[psd_pkg::COORD_W-1], a} - {b[psd_pkg::COORD_W-1], b};
    endfunction

    t_state                             r_state;
    t_state                             n_state;

    logic [psd_pkg::VERT_W-1:0]         r_fence [psd_pkg::MAX_VERTICES];
    logic [psd_pkg::VERT_W-1:0]         r_rd;

    logic [psd_pkg::COORD_W-1:0]        r_px;
    logic [psd_pkg::COORD_W-1:0]        r_py;
    logic [psd_pkg::VERT_W-1:0]         r_v0;
    logic [psd_pkg::VERT_W-1:0]         r_v1;
    logic [psd_pkg::CNT_W-1:0]          r_n;
    logic [psd_pkg::VIDX_W-1:0]         r_i;

    logic [psd_pkg::DIFF_W-1:0]         r_da;
    logic [psd_pkg::DIFF_W-1:0]         r_db;
    logic [psd_pkg::DIFF_W-1:0]         r_dc;
    logic [psd_pkg::DIFF_W-1:0]         r_de;
    logic [psd_pkg::DIFF_W-1:0]         r_ex;
    logic [psd_pkg::DIFF_W-1:0]         r_ey;

    logic [psd_pkg::STEP_W-1:0]         r_step;
    logic [psd_pkg::PROD_W-1:0]         r_pmag;
    logic                               r_pneg;
    t_acc                               r_pdst;
    logic [psd_pkg::SUM_W-1:0]          r_p1;
    logic [psd_pkg::SUM_W-1:0]          r_p2;
    logic [psd_pkg::SUM_W-1:0]          r_cr;
    logic [psd_pkg::LEN_W-1:0]          r_len;

    logic [psd_pkg::CMAG_W-1:0]         r_cmag;
    logic [psd_pkg::CMAG_W-1:0]         r_sqm;
    logic [psd_pkg::C2_W-1:0]           r_c2;
    logic [psd_pkg::SQ_CNT_W-1:0]       r_cnt;
    logic                               r_cpos;

    logic [psd_pkg::C2_W-1:0]           r_a;
    logic [psd_pkg::BS_W-1:0]           r_bs;
    logic [psd_pkg::LS_W-1:0]           r_ls;
    logic [psd_pkg::S_W-1:0]            r_s;
    logic                               r_ph;
    logic [psd_pkg::ROOT_BITS-1:0]      r_d;

    logic                               r_found;
    logic [psd_pkg::ROOT_BITS-1:0]      r_best;
    logic [psd_pkg::VIDX_W-1:0]         r_bseg;
    logic                               r_bpos;

    logic                               r_ovalid;
    psd_pkg::t_result                   r_res;
    psd_pkg::t_result                   n_res;

    logic                               w_last;
    logic [psd_pkg::VIDX_W-1:0]         w_k;
    logic [psd_pkg::VIDX_W-1:0]         w_raddr;
    logic                               w_pop;
    logic                               w_we;
    logic                               w_qry;
    logic [psd_pkg::CNT_W-1:0]          w_ncap;

    logic [psd_pkg::DIFF_W-1:0]         w_op1;
    logic [psd_pkg::DIFF_W-1:0]         w_op2;
    logic                               w_ext;
    logic [psd_pkg::PROD_W-1:0]         w_prod;
    logic                               w_pneg;
    logic [psd_pkg::SUM_W-1:0]          w_pext;
    logic [psd_pkg::SUM_W-1:0]          w_pterm;

    logic                               w_p1_pos;
    logic                               w_p2_pos;
    logic                               w_cr_neg;
    logic [psd_pkg::SUM_W-1:0]          w_cr_abs;

    logic [psd_pkg::T_W-1:0]            w_t;
    logic                               w_take;
    logic [psd_pkg::BS_W-1:0]           w_bsum;
    logic [psd_pkg::DIST_W-1:0]         w_best_ext;
    logic                               w_load;

    // walk control
    assign w_last  = ((psd_pkg::CNT_W'(r_i) + psd_pkg::CNT_W'(1)) == r_n);
    assign w_k     = w_last ? '0 : (r_i + 1'b1);
    assign w_raddr = (r_state == ST_RDK) ? w_k : '0;
    assign w_pop   = (r_state == ST_IDLE) && !i_cmd_empty;
    assign w_we    = w_pop && (i_cmd.kind == psd_pkg::KIND_WRITE);
    assign w_qry   = w_pop && (i_cmd.kind == psd_pkg::KIND_QUERY);
    assign w_ncap  = (i_vertex_count > psd_pkg::CNT_W'(psd_pkg::MAX_VERTICES))
                   ? psd_pkg::CNT_W'(psd_pkg::MAX_VERTICES) : i_vertex_count;
    assign o_cmd_pop = w_pop;

    // multiplier operand schedule
    always_comb begin
        w_op1 = '0;
        w_op2 = '0;
        w_ext = 1'b0;
        case (r_step)
            psd_pkg::STEP_W'(0): begin w_op1 = r_da; w_op2 = r_ex; end
            psd_pkg::STEP_W'(1): begin w_op1 = r_db; w_op2 = r_ey; end
            psd_pkg::STEP_W'(2): begin w_op1 = r_dc; w_op2 = r_ex; end
            psd_pkg::STEP_W'(3): begin w_op1 = r_de; w_op2 = r_ey; end
            psd_pkg::STEP_W'(4): begin w_op1 = r_da; w_op2 = r_de; w_ext = 1'b1; end
            psd_pkg::STEP_W'(5): begin w_op1 = r_db; w_op2 = r_dc; end
            psd_pkg::STEP_W'(6): begin w_op1 = r_ex; w_op2 = r_ex; end
            psd_pkg::STEP_W'(7): begin w_op1 = r_ey; w_op2 = r_ey; end
            default: begin
                w_op1 = '0;
                w_op2 = '0;
            end
        endcase
    end

    assign w_prod  = psd_pkg::PROD_W'(f_mag(w_op1)) * psd_pkg::PROD_W'(f_mag(w_op2));
    assign w_pneg  = w_op1[psd_pkg::DIFF_W-1] ^ w_op2[psd_pkg::DIFF_W-1] ^ w_ext;
    assign w_pext  = psd_pkg::SUM_W'(r_pmag);
    assign w_pterm = r_pneg ? (~w_pext + 1'b1) : w_pext;

    // segment qualification
    assign w_p1_pos = !r_p1[psd_pkg::SUM_W-1] && (r_p1 != '0);
    assign w_p2_pos = !r_p2[psd_pkg::SUM_W-1] && (r_p2 != '0);
    assign w_cr_neg = r_cr[psd_pkg::SUM_W-1];
    assign w_cr_abs = w_cr_neg ? (~r_cr + 1'b1) : r_cr;

    // square root trial
    assign w_t    = psd_pkg::T_W'(r_a) + psd_pkg::T_W'(r_s);
    assign w_take = (w_t <= psd_pkg::T_W'(r_c2));
    assign w_bsum = r_bs + (w_take ? psd_pkg::BS_W'({r_ls, 1'b0}) : '0);

    // result
    assign w_best_ext = psd_pkg::DIST_W'(r_best);
    assign w_load     = (r_state == ST_DONE) && !r_ovalid;

    always_comb begin
        if (r_found) begin
            n_res.sdist    = r_bpos ? w_best_ext : (~w_best_ext + 1'b1);
            n_res.found    = 1'b1;
            n_res.seg      = r_bseg;
            n_res.on_track = r_bpos && (r_best != '0);
        end else begin
            n_res.sdist    = psd_pkg::DIST_MAX;
            n_res.found    = 1'b0;
            n_res.seg      = '0;
            n_res.on_track = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_qry) begin
                    n_state = (w_ncap < psd_pkg::CNT_W'(2)) ? ST_DONE : ST_LDV0;
                end
            end
            ST_LDV0: n_state = ST_RDK;
            ST_RDK:  n_state = ST_LDV1;
            ST_LDV1: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == psd_pkg::STEP_W'(psd_pkg::MUL_STEPS)) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (w_p1_pos && w_p2_pos) begin
                    n_state = ST_SQR;
                end else begin
                    n_state = w_last ? ST_DONE : ST_NEXT;
                end
            end
            ST_SQR: begin
                if (r_cnt == psd_pkg::SQ_CNT_W'(psd_pkg::CMAG_W - 1)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_ph && (r_cnt == psd_pkg::SQ_CNT_W'(psd_pkg::ROOT_BITS - 1))) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = w_last ? ST_DONE : ST_NEXT;
            ST_NEXT: n_state = ST_RDK;
            ST_DONE: begin
                if (!r_ovalid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // fence memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fence[i_cmd.vidx] <= {i_cmd.x, i_cmd.y};
        end
        r_rd <= r_fence[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_qry) begin
                    r_px    <= i_cmd.x;
                    r_py    <= i_cmd.y;
                    r_n     <= w_ncap;
                    r_i     <= '0;
                    r_found <= 1'b0;
                end
            end
            ST_LDV0: r_v0 <= r_rd;
            ST_LDV1: r_v1 <= r_rd;
            ST_DIFF: begin
                r_da   <= f_sub(r_px, r_v0[psd_pkg::VERT_W-1:psd_pkg::COORD_W]);
                r_db   <= f_sub(r_py, r_v0[psd_pkg::COORD_W-1:0]);
                r_dc   <= f_sub(r_v1[psd_pkg::VERT_W-1:psd_pkg::COORD_W], r_px);
                r_de   <= f_sub(r_v1[psd_pkg::COORD_W-1:0], r_py);
                r_ex   <= f_sub(r_v1[psd_pkg::VERT_W-1:psd_pkg::COORD_W],
                                r_v0[psd_pkg::VERT_W-1:psd_pkg::COORD_W]);
                r_ey   <= f_sub(r_v1[psd_pkg::COORD_W-1:0], r_v0[psd_pkg::COORD_W-1:0]);
                r_step <= '0;
                r_p1   <= '0;
                r_p2   <= '0;
                r_cr   <= '0;
                r_len  <= '0;
            end
            ST_MUL: begin
                r_pmag <= w_prod;
                r_pneg <= w_pneg;
                r_pdst <= t_acc'(r_step[2:1]);
                r_step <= r_step + 1'b1;
                if (r_step != '0) begin
                    case (r_pdst)
                        ACC_P1:  r_p1  <= r_p1 + w_pterm;
                        ACC_P2:  r_p2  <= r_p2 + w_pterm;
                        ACC_CR:  r_cr  <= r_cr + w_pterm;
                        ACC_LEN: r_len <= r_len + psd_pkg::LEN_W'(r_pmag);
                        default: r_len <= r_len;
                    endcase
                end
            end
            ST_CHK: begin
                r_cmag <= w_cr_abs[psd_pkg::CMAG_W-1:0];
                r_sqm  <= w_cr_abs[psd_pkg::CMAG_W-1:0];
                r_cpos <= !w_cr_neg && (r_cr != '0);
                r_c2   <= '0;
                r_cnt  <= '0;
            end
            ST_SQR: begin
                r_c2  <= {r_c2[psd_pkg::C2_W-2:0], 1'b0}
                       + (r_sqm[psd_pkg::CMAG_W-1] ? psd_pkg::C2_W'(r_cmag) : '0);
                r_sqm <= {r_sqm[psd_pkg::CMAG_W-2:0], 1'b0};
                if (r_cnt == psd_pkg::SQ_CNT_W'(psd_pkg::CMAG_W - 1)) begin
                    r_cnt <= '0;
                    r_a   <= '0;
                    r_bs  <= '0;
                    r_ls  <= {r_len, (psd_pkg::LS_W - psd_pkg::LEN_W)'(0)};
                    r_ph  <= 1'b0;
                    r_d   <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                if (!r_ph) begin
                    r_s  <= psd_pkg::S_W'(r_bs) + psd_pkg::S_W'(r_ls);
                    r_ph <= 1'b1;
                end else begin
                    if (w_take) begin
                        r_a <= w_t[psd_pkg::C2_W-1:0];
                    end
                    r_bs  <= w_bsum >> 1;
                    r_ls  <= r_ls >> 2;
                    r_d   <= {r_d[psd_pkg::ROOT_BITS-2:0], w_take};
                    r_ph  <= 1'b0;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_CMP: begin
                if (!r_found || (r_d < r_best)) begin
                    r_found <= 1'b1;
                    r_best  <= r_d;
                    r_bseg  <= r_i;
                    r_bpos  <= r_cpos;
                end
            end
            ST_NEXT: begin
                r_i  <= r_i + 1'b1;
                r_v0 <= r_v1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_res_empty = !r_ovalid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_ovalid) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("result not loaded on query completion");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_CHK || r_state == ST_SQR ||
         r_state == ST_ROOT || r_state == ST_CMP) |-> (psd_pkg::CNT_W'(r_i) < r_n))
        else $error("segment index beyond vertex count");

    a_on_track_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.on_track) |-> r_res.found)
        else $error("on_track without a found segment");

    a_pop_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_res_pop) |=> (r_ovalid && $stable(r_res)))
        else $error("waiting result changed");
`endif

endmodule

>>> hdl/polyline_signed_distance_core.sv
// ----------------------------------------------------------------------------
// polyline_signed_distance_core
// Write beat: passes the input stage and queue, one per cycle while the queue has room.
// Query: the segment walker visits each segment in turn, and each segment
// the point projects into also runs through the squaring and root of the
// shared bit-serial unit; one query is worked at a time.
// Reset: synchronous active low; clears control and vertex_count, the fence
// memory keeps its contents.
// ----------------------------------------------------------------------------
module polyline_signed_distance_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_opcode,
    input  logic [psd_pkg::VIDX_W-1:0]          i_vertex_index,
    input  logic signed [psd_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [psd_pkg::DIST_W-1:0]   o_signed_distance,
    output logic                                o_found,
    output logic [psd_pkg::VIDX_W-1:0]          o_segment_index,
    output logic                                o_on_track,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psd_pkg::APB_AW-1:0]          paddr,
    input  logic [psd_pkg::APB_DW-1:0]          pwdata,
    output logic [psd_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    logic [psd_pkg::CNT_W-1:0] r_vertex_count;
    logic                      w_cfg_sel;
    logic                      w_cfg_wr;

    logic                      w_q_push;
    psd_pkg::t_cmd             w_q_wdata;
    logic                      w_q_full;
    logic                      w_q_empty;
    logic                      w_q_pop;
    psd_pkg::t_cmd             w_q_rdata;
    psd_pkg::t_result          w_res;

    assign w_cfg_sel = (paddr[psd_pkg::APB_AW-1] == psd_pkg::REG_VERTEX_COUNT);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_sel;
    assign pready    = 1'b1;
    assign prdata    = w_cfg_sel ? psd_pkg::APB_DW'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (w_cfg_wr) begin
            r_vertex_count <= pwdata[psd_pkg::CNT_W-1:0];
        end
    end

    psd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_opcode       (i_opcode),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_q_push       (w_q_push),
        .o_q_data       (w_q_wdata),
        .i_q_full       (w_q_full)
    );

    psd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_rdata)
    );

    psd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_cmd_empty    (w_q_empty),
        .i_cmd          (w_q_rdata),
        .o_cmd_pop      (w_q_pop),
        .i_res_pop      (pop),
        .o_res_empty    (empty),
        .o_res          (w_res)
    );

    assign o_signed_distance = w_res.sdist;
    assign o_found           = w_res.found;
    assign o_segment_index   = w_res.seg;
    assign o_on_track        = w_res.on_track;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the polyline signed distance core. Loads vertex sets into the
// fence store and queries points against them. Expected results come from a
// local exact-integer model of the nearest projecting segment. Both sides
// idle at random, and the vertex count register is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RAND_PHASES  = 10;
    localparam logic [psd_pkg::APB_AW-1:0] ADDR_VERTEX_COUNT =
        psd_pkg::APB_AW'(4 * psd_pkg::REG_VERTEX_COUNT);
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    logic                               i_opcode = 1'b0;
    logic [psd_pkg::VIDX_W-1:0]         i_vertex_index = '0;
    logic signed [psd_pkg::COORD_W-1:0] i_coord_x = '0;
    logic signed [psd_pkg::COORD_W-1:0] i_coord_y = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    logic signed [psd_pkg::DIST_W-1:0]  o_signed_distance;
    logic                               o_found;
    logic [psd_pkg::VIDX_W-1:0]         o_segment_index;
    logic                               o_on_track;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [psd_pkg::APB_AW-1:0]         paddr = '0;
    logic [psd_pkg::APB_DW-1:0]         pwdata = '0;
    logic [psd_pkg::APB_DW-1:0]         prdata;
    logic                               pready;

    polyline_signed_distance_core u_dut (.*);

    always #6 i_clk = ~i_clk;

    psd_pkg::t_cmd      cmd_q[$];
    psd_pkg::t_result   exp_q[$];
    logic signed [31:0] fence_x[psd_pkg::MAX_VERTICES];
    logic signed [31:0] fence_y[psd_pkg::MAX_VERTICES];
    logic [psd_pkg::CNT_W-1:0] vertex_count = '0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          cycles = 0;

    // floor(cmag / sqrt(len2)), saturated
    function automatic logic [31:0] floor_dist(logic [127:0] cmag, logic [127:0] len2);
        logic [255:0] c2, l, dd;
        logic [31:0]  lo, hi, mid;
        c2 = 256'(cmag) * 256'(cmag);
        l  = 256'(len2);
        dd = 256'(psd_pkg::DIST_MAX);
        if (dd * dd * l <= c2) return psd_pkg::DIST_MAX;
        lo = '0;
        hi = psd_pkg::DIST_MAX;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            dd  = 256'(mid);
            if (dd * dd * l <= c2) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic psd_pkg::t_result nearest_segment(logic signed [31:0] px,
                                                         logic signed [31:0] py);
        psd_pkg::t_result r;
        int n, k;
        logic signed [127:0] qx, qy, x0, y0, x1, y1, ex, ey, p1, p2, cr, len2;
        logic [31:0] best, d;
        logic found, best_pos;
        int best_seg;
        n = (vertex_count > psd_pkg::MAX_VERTICES) ? int'(psd_pkg::MAX_VERTICES)
                                                   : int'(vertex_count);
        qx = px;
        qy = py;
        found = 1'b0;
        best_pos = 1'b0;
        best = '0;
        best_seg = 0;
        for (int i = 0; i < n; i++) begin
            k  = (i + 1 == n) ? 0 : i + 1;
            x0 = fence_x[i];
            y0 = fence_y[i];
            x1 = fence_x[k];
            y1 = fence_y[k];
            ex = x1 - x0;
            ey = y1 - y0;
            p1 = (qx - x0) * ex + (qy - y0) * ey;
            p2 = (qx - x1) * (-ex) + (qy - y1) * (-ey);
            if (p1 <= 0 || p2 <= 0) continue;
            cr   = (x0 - qx) * (y1 - qy) - (y0 - qy) * (x1 - qx);
            len2 = ex * ex + ey * ey;
            d    = floor_dist((cr < 0) ? -cr : cr, len2);
            if (!found || d < best) begin
                found    = 1'b1;
                best     = d;
                best_seg = i;
                best_pos = (cr > 0);
            end
        end
        if (!found) begin
            r.sdist = psd_pkg::DIST_MAX;
            r.found = 1'b0;
            r.seg = '0;
            r.on_track = 1'b0;
        end else begin
            r.sdist = best_pos ? best : -best;
            r.found = 1'b1;
            r.seg = best_seg[psd_pkg::VIDX_W-1:0];
            r.on_track = best_pos && (best != 0);
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (push && !full) begin
                if (cmd_q[0].kind == psd_pkg::KIND_WRITE) begin
                    fence_x[cmd_q[0].vidx] = cmd_q[0].x;
                    fence_y[cmd_q[0].vidx] = cmd_q[0].y;
                end else begin
                    exp_q.insert(exp_q.size(), nearest_segment(cmd_q[0].x, cmd_q[0].y));
                end
                void'(cmd_q.pop_front());
            end
            if (!(push && full)) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    push           <= 1'b1;
                    i_opcode       <= cmd_q[0].kind;
                    i_vertex_index <= cmd_q[0].vidx;
                    i_coord_x      <= cmd_q[0].x;
                    i_coord_y      <= cmd_q[0].y;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (exp_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    if (o_signed_distance !== exp_q[0].sdist) begin
                        $error("signed_distance exp %0d got %0d", exp_q[0].sdist,
                               o_signed_distance);
                        errors++;
                    end
                    if (o_found !== exp_q[0].found) begin
                        $error("found exp %0b got %0b", exp_q[0].found, o_found);
                        errors++;
                    end
                    if (o_segment_index !== exp_q[0].seg) begin
                        $error("segment_index exp %0d got %0d", exp_q[0].seg,
                               o_segment_index);
                        errors++;
                    end
                    if (o_on_track !== exp_q[0].on_track) begin
                        $error("on_track exp %0b got %0b", exp_q[0].on_track, o_on_track);
                        errors++;
                    end
                    void'(exp_q.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic add_write(int idx, logic signed [31:0] x, logic signed [31:0] y);
        psd_pkg::t_cmd c;
        c.kind = psd_pkg::KIND_WRITE;
        c.vidx = idx[psd_pkg::VIDX_W-1:0];
        c.x = x;
        c.y = y;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic add_query(logic signed [31:0] x, logic signed [31:0] y);
        psd_pkg::t_cmd c;
        c.kind = psd_pkg::KIND_QUERY;
        c.vidx = psd_pkg::VIDX_W'($urandom);
        c.x = x;
        c.y = y;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic wait_idle();
        while (cmd_q.size() > 0 || push || exp_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(int value);
        wait_idle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= psd_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        vertex_count = value[psd_pkg::CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(logic wide, int center);
        if (wide) return $urandom;
        return center + $signed($urandom_range(8192)) - 4096;
    endfunction

    initial begin
        int n, v;
        logic wide;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 31;
        recv_idle = 67;

        // directed: empty fence, then a 1024 by 1024 square
        set_vertex_count(0);
        add_query(0, 0);
        add_query(C_MIN, C_MAX);
        add_write(0, 0, 0);
        add_write(1, 1024, 0);
        add_write(2, 1024, 1024);
        add_write(3, 0, 1024);
        add_write(1023, C_MIN, C_MAX);
        add_write(512, C_MAX, C_MIN);
        set_vertex_count(1);
        add_query(5, 5);
        set_vertex_count(4);
        add_query(512, 300);
        add_query(512, 512);
        add_query(2000, 500);
        add_query(512, 0);
        add_query(512, -300);
        add_query(-100, -100);
        add_query(1024, 1024);
        add_query(C_MAX, C_MIN);
        add_query(C_MIN, C_MAX);
        // degenerate segment, then saturating triangle
        set_vertex_count(3);
        add_write(0, 0, 0);
        add_write(1, 0, 0);
        add_write(2, 1024, 1024);
        add_query(600, 100);
        add_write(0, C_MIN, C_MIN);
        add_write(1, C_MAX, C_MIN);
        add_write(2, 0, C_MAX);
        add_query(0, C_MAX);
        add_query(0, C_MIN + 5);

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < RAND_PHASES / 3) begin
                send_idle = 31;
                recv_idle = 67;
            end else if (p < 2 * RAND_PHASES / 3) begin
                send_idle = 67;
                recv_idle = 31;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            n = $urandom_range(3, 10);
            wide = ($urandom_range(2) == 0);
            set_vertex_count(($urandom_range(9) == 0) ? 2 : n);
            for (int i = 0; i < n; i++) add_write(i, rand_coord(wide, 0), rand_coord(wide, 0));
            for (int j = 0; j < 45; j++) begin
                v = $urandom_range(9);
                if (v < 2) begin
                    add_write($urandom_range(n - 1), rand_coord(wide, 0), rand_coord(wide, 0));
                end else if (v < 3) begin
                    add_write($urandom_range(n, psd_pkg::MAX_VERTICES - 1), $urandom, $urandom);
                end else begin
                    add_query(rand_coord(wide, 0), rand_coord(wide, 0));
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> polyline_signed_distance_core.f
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_queue.sv
hdl/psd_back.sv
hdl/polyline_signed_distance_core.sv
dv/tb_top.sv
